/* hw/rtl/gmds_pkg.sv */
// ----------------------------------------------------------------------------
// gmds_pkg
// Shared types and codes of the grid maze depth-first solver: request,
// result and configuration records, request kinds, register indexes and
// neighbour directions.
// ----------------------------------------------------------------------------
`default_nettype none

package gmds_pkg;

  // request kinds
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_SOLVE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAZE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAZE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_X       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END_Y       = 3'd5;
  localparam int unsigned CFG_DATA_W = 5;

  // neighbour order of the walk
  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef struct packed {
    logic [4:0] maze_width;
    logic [4:0] maze_height;
    logic [3:0] start_x;
    logic [3:0] start_y;
    logic [3:0] end_x;
    logic [3:0] end_y;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] pos_x;
    logic [3:0] pos_y;
    logic [3:0] walls;
    logic [7:0] path_index;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [8:0] path_length;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/gmds_cfg.sv */
// ----------------------------------------------------------------------------
// gmds_cfg
// Configuration register file: grid size, start cell and goal cell, written
// through a plain index/data write port.
// ----------------------------------------------------------------------------
`default_nettype none

module gmds_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            we_i,
  input  wire logic [gmds_pkg::CFG_IDX_W-1:0]  idx_i,
  input  wire logic [gmds_pkg::CFG_DATA_W-1:0] data_i,
  output gmds_pkg::cfg_t                       cfg_o
);

  gmds_pkg::cfg_t cfg_q, cfg_d;

  // register decode, unknown indexes change nothing
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        gmds_pkg::CFG_MAZE_WIDTH:  cfg_d.maze_width  = data_i;
        gmds_pkg::CFG_MAZE_HEIGHT: cfg_d.maze_height = data_i;
        gmds_pkg::CFG_START_X:     cfg_d.start_x     = data_i[3:0];
        gmds_pkg::CFG_START_Y:     cfg_d.start_y     = data_i[3:0];
        gmds_pkg::CFG_END_X:       cfg_d.end_x       = data_i[3:0];
        gmds_pkg::CFG_END_Y:       cfg_d.end_y       = data_i[3:0];
        default:                   cfg_d             = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.maze_width  <= 5'd16;
      cfg_q.maze_height <= 5'd16;
      cfg_q.start_x     <= 4'd0;
      cfg_q.start_y     <= 4'd0;
      cfg_q.end_x       <= 4'd15;
      cfg_q.end_y       <= 4'd15;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/gmds_nbr.sv */
// ----------------------------------------------------------------------------
// gmds_nbr
// Neighbour unit shared by every step of the walk: for one direction it gives
// the neighbouring cell and whether it lies in bounds and is not walled off.
// ----------------------------------------------------------------------------
`default_nettype none

module gmds_nbr #(
  parameter int unsigned MAX_DIM = 16,
  localparam int unsigned CW = $clog2(MAX_DIM),
  localparam int unsigned HW = CW + 1
) (
  input  wire logic [CW-1:0] cur_x_i,
  input  wire logic [CW-1:0] cur_y_i,
  input  wire gmds_pkg::dir_e dir_i,
  input  wire logic [HW-1:0] dim_w_i,
  input  wire logic [HW-1:0] dim_h_i,
  input  wire logic [3:0]    walls_i,
  output logic               open_o,
  output logic [CW-1:0]      nb_x_o,
  output logic [CW-1:0]      nb_y_o
);

  logic [HW-1:0] x_inc, y_inc;

  assign x_inc = {1'b0, cur_x_i} + HW'(1);
  assign y_inc = {1'b0, cur_y_i} + HW'(1);

  // one direction per call, wall bit order up, down, left, right
  always_comb begin
    nb_x_o = cur_x_i;
    nb_y_o = cur_y_i;
    open_o = 1'b0;
    unique case (dir_i)
      gmds_pkg::DIR_UP: begin
        nb_y_o = cur_y_i - CW'(1);
        open_o = (cur_y_i != '0) && !walls_i[0];
      end
      gmds_pkg::DIR_DOWN: begin
        nb_y_o = y_inc[CW-1:0];
        open_o = (y_inc < dim_h_i) && !walls_i[1];
      end
      gmds_pkg::DIR_LEFT: begin
        nb_x_o = cur_x_i - CW'(1);
        open_o = (cur_x_i != '0) && !walls_i[2];
      end
      gmds_pkg::DIR_RIGHT: begin
        nb_x_o = x_inc[CW-1:0];
        open_o = (x_inc < dim_w_i) && !walls_i[3];
      end
      default: begin
        open_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/gmds_seq.sv */
// ----------------------------------------------------------------------------
// gmds_seq
// Sequencer of the solver: holds the wall, visited and path memories and
// steps the depth-first walk one memory access at a time through the shared
// neighbour unit. Also serves wall loads and path read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module gmds_seq #(
  parameter int unsigned MAX_DIM = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire gmds_pkg::cfg_t cfg_i,
  input  wire logic     req_valid_i,
  input  wire gmds_pkg::req_t req_i,
  output logic          req_ready_o,
  output logic          res_valid_o,
  output gmds_pkg::res_t res_o,
  input  wire logic     res_ready_i
);

  localparam int unsigned CW     = $clog2(MAX_DIM);
  localparam int unsigned HW     = CW + 1;
  localparam int unsigned AW     = 2 * CW;
  localparam int unsigned NCELLS = MAX_DIM * MAX_DIM;
  localparam int unsigned SAW    = $clog2(NCELLS);
  localparam int unsigned DW     = $clog2(NCELLS + 1);
  localparam int unsigned CMPW   = (DW > 8) ? DW : 8;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDW  = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_INIT = 4'd3;
  localparam logic [3:0] S_CHK  = 4'd4;
  localparam logic [3:0] S_NB   = 4'd5;
  localparam logic [3:0] S_NBW  = 4'd6;
  localparam logic [3:0] S_POP  = 4'd7;
  localparam logic [3:0] S_POPW = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]    state_q, state_d;
  logic [DW-1:0] depth_q, depth_d;
  logic          solved_q, solved_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] nb_q, nb_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [1:0]    dir_q, dir_d;
  logic          hit_q, hit_d;
  logic [3:0]    cx_q, cx_d;
  logic [3:0]    cy_q, cy_d;
  logic          bad_q, bad_d;

  // memories
  logic [3:0]    wall_mem  [1 << AW];
  logic          vis_mem   [1 << AW];
  logic [AW-1:0] stack_mem [NCELLS];
  logic [3:0]    wall_rd_q;
  logic          vis_rd_q;
  logic [AW-1:0] stack_rd_q;

  logic          wall_we, vis_we, vis_wd, stack_we;
  logic [AW-1:0] wall_waddr, vis_waddr, vis_raddr, stack_wd;
  logic [SAW-1:0] stack_waddr, stack_raddr;

  // clamped grid size and cell coordinates
  logic [HW-1:0] dim_w, dim_h;
  logic [AW-1:0] start_cell, goal_cell;
  logic          accept, load_ok, bad_now;
  logic [CMPW-1:0] idx_ext, depth_ext;
  logic [DW-1:0] depth_dec, depth_dec2;
  logic          nb_open;
  logic [CW-1:0] nb_x, nb_y;
  logic [CW+3:0] rd_x_ext, rd_y_ext;
  logic [DW+8:0] len_ext;

  always_comb begin
    if (cfg_i.maze_width == '0) begin
      dim_w = HW'(1);
    end else if (int'(cfg_i.maze_width) > MAX_DIM) begin
      dim_w = HW'(MAX_DIM);
    end else begin
      dim_w = HW'(cfg_i.maze_width);
    end
    if (cfg_i.maze_height == '0) begin
      dim_h = HW'(1);
    end else if (int'(cfg_i.maze_height) > MAX_DIM) begin
      dim_h = HW'(MAX_DIM);
    end else begin
      dim_h = HW'(cfg_i.maze_height);
    end
  end

  assign bad_now = (int'(cfg_i.start_x) >= int'(dim_w)) ||
                   (int'(cfg_i.start_y) >= int'(dim_h)) ||
                   (int'(cfg_i.end_x)   >= int'(dim_w)) ||
                   (int'(cfg_i.end_y)   >= int'(dim_h));
  assign start_cell = {CW'(cfg_i.start_y), CW'(cfg_i.start_x)};
  assign goal_cell  = {CW'(cfg_i.end_y), CW'(cfg_i.end_x)};

  assign accept  = req_valid_i && req_ready_o;
  assign load_ok = (int'(req_i.pos_x) < MAX_DIM) && (int'(req_i.pos_y) < MAX_DIM);

  assign idx_ext    = CMPW'(req_i.path_index);
  assign depth_ext  = CMPW'(depth_q);
  assign depth_dec  = depth_q - DW'(1);
  assign depth_dec2 = depth_q - DW'(2);

  // shared neighbour unit
  gmds_nbr #(
    .MAX_DIM (MAX_DIM)
  ) u_nbr (
    .cur_x_i (cur_q[CW-1:0]),
    .cur_y_i (cur_q[AW-1:CW]),
    .dir_i   (gmds_pkg::dir_e'(dir_q)),
    .dim_w_i (dim_w),
    .dim_h_i (dim_h),
    .walls_i (wall_rd_q),
    .open_o  (nb_open),
    .nb_x_o  (nb_x),
    .nb_y_o  (nb_y)
  );

  // memory ports
  assign wall_we     = accept && (req_i.kind == gmds_pkg::KIND_LOAD) && load_ok;
  assign wall_waddr  = {CW'(req_i.pos_y), CW'(req_i.pos_x)};
  assign vis_raddr   = {nb_y, nb_x};
  assign stack_waddr = depth_q[SAW-1:0];
  assign stack_wd    = (state_q == S_INIT) ? start_cell : nb_q;
  assign stack_raddr = (state_q == S_POP) ? depth_dec2[SAW-1:0] : idx_ext[SAW-1:0];

  always_comb begin
    vis_we    = 1'b0;
    vis_wd    = 1'b0;
    vis_waddr = clr_q;
    stack_we  = 1'b0;
    unique case (state_q)
      S_CLR: begin
        vis_we = 1'b1;
      end
      S_INIT: begin
        vis_we    = 1'b1;
        vis_wd    = 1'b1;
        vis_waddr = start_cell;
        stack_we  = 1'b1;
      end
      S_NBW: begin
        if (!vis_rd_q && (depth_q < DW'(NCELLS))) begin
          vis_we    = 1'b1;
          vis_wd    = 1'b1;
          vis_waddr = nb_q;
          stack_we  = 1'b1;
        end
      end
      default: begin
        vis_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wall_we) begin
      wall_mem[wall_waddr] <= req_i.walls;
    end
    wall_rd_q <= wall_mem[cur_q];
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wd;
    end
    vis_rd_q <= vis_mem[vis_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= stack_wd;
    end
    stack_rd_q <= stack_mem[stack_raddr];
  end

  // walk sequencer
  always_comb begin
    state_d  = state_q;
    depth_d  = depth_q;
    solved_d = solved_q;
    cur_d    = cur_q;
    nb_d     = nb_q;
    clr_d    = clr_q;
    dir_d    = dir_q;
    hit_d    = hit_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    bad_d    = bad_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cx_d = '0;
          cy_d = '0;
          priority case (req_i.kind)
            gmds_pkg::KIND_SOLVE: begin
              depth_d  = '0;
              solved_d = 1'b0;
              clr_d    = '0;
              bad_d    = bad_now;
              state_d  = S_CLR;
            end
            gmds_pkg::KIND_READ: begin
              hit_d   = idx_ext < depth_ext;
              state_d = S_RDW;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_RDW: begin
        if (hit_q) begin
          cx_d = rd_x_ext[3:0];
          cy_d = rd_y_ext[3:0];
        end
        state_d = S_DONE;
      end
      S_CLR: begin
        clr_d = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = bad_q ? S_DONE : S_INIT;
        end
      end
      S_INIT: begin
        depth_d = DW'(1);
        cur_d   = start_cell;
        state_d = S_CHK;
      end
      S_CHK: begin
        // wall bits of the current cell are read here and are ready in S_NB
        dir_d = gmds_pkg::DIR_UP;
        if (cur_q == goal_cell) begin
          solved_d = 1'b1;
          state_d  = S_DONE;
        end else begin
          state_d = S_NB;
        end
      end
      S_NB: begin
        if (nb_open) begin
          nb_d    = {nb_y, nb_x};
          state_d = S_NBW;
        end else if (dir_q == gmds_pkg::DIR_RIGHT) begin
          state_d = S_POP;
        end else begin
          dir_d = dir_q + 2'd1;
        end
      end
      S_NBW: begin
        if (!vis_rd_q) begin
          // first free neighbour: push it, or back up when the stack is full
          if (depth_q < DW'(NCELLS)) begin
            depth_d = depth_q + DW'(1);
            cur_d   = nb_q;
            state_d = S_CHK;
          end else begin
            state_d = S_POP;
          end
        end else if (dir_q == gmds_pkg::DIR_RIGHT) begin
          state_d = S_POP;
        end else begin
          dir_d   = dir_q + 2'd1;
          state_d = S_NB;
        end
      end
      S_POP: begin
        depth_d = depth_dec;
        state_d = (depth_q == DW'(1)) ? S_DONE : S_POPW;
      end
      S_POPW: begin
        cur_d   = stack_rd_q;
        state_d = S_CHK;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      depth_q  <= '0;
      solved_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      depth_q  <= depth_d;
      solved_q <= solved_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    nb_q  <= nb_d;
    clr_q <= clr_d;
    dir_q <= dir_d;
    hit_q <= hit_d;
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    bad_q <= bad_d;
  end

  // result record
  assign rd_x_ext = {4'b0, stack_rd_q[CW-1:0]};
  assign rd_y_ext = {4'b0, stack_rd_q[AW-1:CW]};
  assign len_ext  = {9'b0, depth_q};

  assign req_ready_o       = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.found       = solved_q;
  assign res_o.path_length = len_ext[8:0];
  assign res_o.cell_x      = cx_q;
  assign res_o.cell_y      = cy_q;

endmodule

`default_nettype wire

/* hw/rtl/grid_maze_dfs_solver_top.sv */
// ----------------------------------------------------------------------------
// grid_maze_dfs_solver_top
// Depth-first grid maze solver: wall loads, solve and path read-back on one
// request stream, one result per request on the output stream.
//
//   port group  dir  role
//   s_axis_*    in   requests: tuser kind, tdata cell, walls, path index
//   m_axis_*    out  results: found, path length, path cell
//   cfg_*       in   register writes: size, start and goal cells
//
// a load goes from acceptance straight to the result state, a read-back
// through S_RDW first; the result shows on m_axis as s_axis_tready returns
// a solve clears the visited map one entry a cycle, all 4**clog2(MAX_DIM)
// entries (256 at MAX_DIM 16), then pushes the start cell, or goes to the
// result when a start or goal coordinate lies outside the grid
// each walk step checks the cell against the goal, then tries neighbours in
// S_NB (and S_NBW if open); a back-up pops via S_POP and S_POPW and rescans from up
// reset returns the registers to a 16 x 16 grid from (0,0) to (15,15)
// s_axis_tready is low from an accepted request until its result has moved
// into the output register, which holds a stalled result
// ----------------------------------------------------------------------------
`default_nettype none

module grid_maze_dfs_solver_top #(
  parameter int unsigned MAX_DIM = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [23:0]                     s_axis_tdata,  // pos_x, pos_y, walls, path_index
  input  wire logic [1:0]                      s_axis_tuser,  // kind
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [23:0]                          m_axis_tdata,  // found, path_length, cell_x, cell_y
  input  wire logic                            cfg_we_i,
  input  wire logic [gmds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [gmds_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  gmds_pkg::cfg_t cfg;
  gmds_pkg::req_t req;
  gmds_pkg::res_t res;
  logic           res_valid, res_ready;
  logic           out_valid_q, out_valid_d;
  logic [23:0]    out_data_q, out_data_d;

  // unpack the request
  assign req.kind       = s_axis_tuser;
  assign req.pos_x      = s_axis_tdata[3:0];
  assign req.pos_y      = s_axis_tdata[7:4];
  assign req.walls      = s_axis_tdata[11:8];
  assign req.path_index = s_axis_tdata[19:12];

  gmds_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  gmds_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_valid_i (s_axis_tvalid),
    .req_i       (req),
    .req_ready_o (s_axis_tready),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_data_d = {6'b0, res.cell_y, res.cell_x, res.path_length, res.found};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
